// ===== hw/rtl/combined_lcg_shuffle_random_defines.svh =====
// Assertion macros for the combined generator with shuffle table.
// Depends on nothing; included by the top level only.
`ifndef COMBINED_LCG_SHUFFLE_RANDOM_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RANDOM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLSR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CLSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/clsr_pkg.sv =====
// Shared types, constants and the modular reduction function of the generator.
// Depends on nothing; imported by the controller, the datapath, the top level and the testbench.
`default_nettype none

package clsr_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int WARM_STEPS = TABLE_DEPTH + 8;
   localparam int CNT_W = $clog2(WARM_STEPS);

   localparam int PROD_W = 48;
   localparam int FOLD_W = 8;

   localparam logic [31:0] MOD_A = 32'd2147483563;
   localparam logic [31:0] MOD_B = 32'd2147483399;
   localparam logic [FOLD_W-1:0] FOLD_A = 8'd85;
   localparam logic [FOLD_W-1:0] FOLD_B = 8'd249;
   localparam logic [15:0] MUL_A = 16'd40014;
   localparam logic [15:0] MUL_B = 16'd40692;
   localparam logic [30:0] WRAP_ADD = 31'd2147483562;
   localparam logic [30:0] SAMPLE_CAP = 31'd2147483305;
   localparam logic [30:0] SECOND_RESET = 31'd123456789;

   localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483562 / TABLE_DEPTH;
   localparam int RECIP_SHIFT = 40;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
   localparam int RECIP_W = $clog2(RECIP + 64'd1);
   localparam int QUO_W = IDX_W + 1;
   localparam int PROD_R_W = RECIP_SHIFT + QUO_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WARM_MUL,
      ST_WARM_RED,
      ST_MUL,
      ST_RED,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic warm_mul;
      logic warm_red;
      logic step_mul;
      logic step_red;
      logic rd;
      logic wr;
   } dp_cmd_type;

   typedef struct packed {
      logic reseed;
      logic warm_done;
   } dp_status_type;

   // The modulus is 2^31 minus fold, so the high part folds back in with one
   // multiply by fold and a single conditional subtraction.
   function automatic logic [30:0] mod_reduce(input logic [PROD_W-1:0] prod,
                                              input logic [FOLD_W-1:0] fold,
                                              input logic [31:0] modulus);
      logic [31:0] sum;
      sum = {1'b0, prod[30:0]} + 32'(prod[PROD_W-1:31]) * 32'(fold);
      mod_reduce = (sum >= modulus) ? 31'(sum - modulus) : sum[30:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clsr_ctrl.sv =====
// Sequencing state machine and result-valid register of the generator.
// Depends on clsr_pkg; drives the datapath through dp_cmd_type.
`default_nettype none

module clsr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire clsr_pkg::dp_status_type status,
   output clsr_pkg::dp_cmd_type        cmd
);
   import clsr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.reseed ? ST_WARM_MUL : ST_MUL;
            end
         end
         ST_WARM_MUL: state_in = ST_WARM_RED;
         ST_WARM_RED: state_in = status.warm_done ? ST_MUL : ST_WARM_MUL;
         ST_MUL:      state_in = ST_RED;
         ST_RED:      state_in = ST_READ;
         ST_READ:     state_in = ST_WRITE;
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_WARM_MUL: cmd.warm_mul = 1'b1;
         ST_WARM_RED: cmd.warm_red = 1'b1;
         ST_MUL:      cmd.step_mul = 1'b1;
         ST_RED:      cmd.step_red = 1'b1;
         ST_READ:     cmd.rd = 1'b1;
         ST_WRITE:    cmd.wr = !rsp_valid_ff || rsp_ready;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      priority if (cmd.wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/clsr_dp.sv =====
// Datapath: both generators, the slot index, the shuffle table and the result word.
// Depends on clsr_pkg; commanded by clsr_ctrl.
`default_nettype none

module clsr_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire clsr_pkg::dp_cmd_type cmd,
   input  wire logic signed [31:0]   req_seed_in,
   output clsr_pkg::dp_status_type   status,
   output logic [30:0]               rsp_seed_out,
   output logic [30:0]               rsp_sample
);
   import clsr_pkg::*;

   logic [31:0]            raw;
   logic                   reseed;
   logic [31:0]            seed_start;

   logic [31:0]            first_ff;
   logic [31:0]            second_work_ff;
   logic [30:0]            second_gen_ff;
   logic [30:0]            last_ff;
   logic [CNT_W-1:0]       warm_cnt_ff;
   logic [PROD_W-1:0]      prod_a_ff;
   logic [PROD_W-1:0]      prod_b_ff;
   logic [PROD_R_W-1:0]    prod_r_ff;
   logic [IDX_W-1:0]       slot_ff;
   logic [30:0]            rdata_ff;
   logic [30:0]            seed_out_ff;
   logic [30:0]            sample_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [30:0]            table_mem [TABLE_DEPTH];

   logic [30:0]            red_a;
   logic [30:0]            red_b;
   logic [QUO_W-1:0]       q_est;
   logic [31:0]            q_mul;
   logic [31:0]            q_rem;
   logic [QUO_W-1:0]       q_fix;
   logic [IDX_W-1:0]       slot_in;
   logic                   warm_store;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_addr;
   logic [30:0]            mem_data;
   logic [31:0]            diff;
   logic [30:0]            fresh;

   assign raw = 32'(req_seed_in);
   assign reseed = (raw == 32'd0) || raw[31];
   assign seed_start = (raw == 32'd0) ? 32'd1 : (32'd0 - raw);

   assign red_a = mod_reduce(prod_a_ff, FOLD_A, MOD_A);
   assign red_b = mod_reduce(prod_b_ff, FOLD_B, MOD_B);

   // Slot is last output over SLOT_DIV: reciprocal estimate, then one correction.
   assign q_est = prod_r_ff[RECIP_SHIFT +: QUO_W];
   assign q_mul = 32'(q_est) * 32'(SLOT_DIV);
   assign q_rem = {1'b0, last_ff} - q_mul;
   assign q_fix = (q_rem >= 32'(SLOT_DIV)) ? q_est + QUO_W'(1) : q_est;
   assign slot_in = (q_fix >= QUO_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                   : q_fix[IDX_W-1:0];

   assign diff = (rdata_ff > second_gen_ff)
                 ? {1'b0, rdata_ff} - {1'b0, second_gen_ff}
                 : {1'b0, WRAP_ADD} + {1'b0, rdata_ff} - {1'b0, second_gen_ff};
   assign fresh = diff[30:0];

   assign warm_store = cmd.warm_red && (warm_cnt_ff < CNT_W'(TABLE_DEPTH));
   assign mem_we = warm_store || cmd.wr;
   assign mem_addr = cmd.wr ? slot_ff : warm_cnt_ff[IDX_W-1:0];
   assign mem_data = cmd.wr ? first_ff[30:0] : red_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_gen_ff <= SECOND_RESET;
         last_ff <= 31'd0;
         valid_ff <= '0;
      end else begin
         if (cmd.step_red) begin
            second_gen_ff <= red_b;
         end
         if (cmd.warm_red && (warm_cnt_ff == '0)) begin
            last_ff <= red_a;
         end else if (cmd.wr) begin
            last_ff <= fresh;
         end
         if (mem_we) begin
            valid_ff[mem_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_data;
      end
      if (cmd.rd) begin
         rdata_ff <= valid_ff[slot_ff] ? table_mem[slot_ff] : 31'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff <= reseed ? seed_start : raw;
         second_work_ff <= reseed ? seed_start : {1'b0, second_gen_ff};
         warm_cnt_ff <= CNT_W'(WARM_STEPS - 1);
      end
      if (cmd.warm_mul || cmd.step_mul) begin
         prod_a_ff <= PROD_W'(first_ff) * PROD_W'(MUL_A);
      end
      if (cmd.step_mul) begin
         prod_b_ff <= PROD_W'(second_work_ff) * PROD_W'(MUL_B);
         prod_r_ff <= PROD_R_W'(last_ff) * PROD_R_W'(RECIP_W'(RECIP));
      end
      if (cmd.warm_red) begin
         first_ff <= {1'b0, red_a};
         warm_cnt_ff <= warm_cnt_ff - CNT_W'(1);
      end
      if (cmd.step_red) begin
         first_ff <= {1'b0, red_a};
         slot_ff <= slot_in;
      end
      if (cmd.wr) begin
         seed_out_ff <= first_ff[30:0];
         sample_ff <= (fresh > SAMPLE_CAP) ? SAMPLE_CAP : fresh;
      end
   end

   assign status.reseed = reseed;
   assign status.warm_done = (warm_cnt_ff == '0);
   assign rsp_seed_out = seed_out_ff;
   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/combined_lcg_shuffle_random.sv =====
// Top level of the combined two-generator random source with a shuffle table.
// Depends on clsr_pkg, clsr_ctrl, clsr_dp and combined_lcg_shuffle_random_defines.svh.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_ready   req_seed_in (32 bits, signed)
//   rsp      out        rsp_valid/rsp_ready   rsp_seed_out, rsp_sample (31 bits each)
//
// An ordinary word goes from acceptance to the next acceptance through these steps:
// multiply, reduce with slot index, registered table read, then table update and result.
// A seed of zero or below adds forty warm-up steps, each a multiply and a reduce, on
// the shared multiply and reduce unit of the first generator.
// Reset is synchronous; it restores the second generator, clears the last output and
// marks every table entry empty. A stalled result holds only the final update step.
`default_nettype none
`include "combined_lcg_shuffle_random_defines.svh"

module combined_lcg_shuffle_random (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_seed_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [30:0]             rsp_seed_out,
   output logic [30:0]             rsp_sample
);
   import clsr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   clsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   clsr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_seed_in  (req_seed_in),
      .status       (status),
      .rsp_seed_out (rsp_seed_out),
      .rsp_sample   (rsp_sample)
   );

   `CLSR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CLSR_ASSERT_SAME(a_rsp_from_update, clock, reset, $rose(rsp_valid), $past(cmd.wr))
   `CLSR_ASSERT_SAME(a_update_needs_room, clock, reset, cmd.wr, !rsp_valid || rsp_ready)
   `CLSR_ASSERT_SAME(a_sample_capped, clock, reset, rsp_valid, rsp_sample <= SAMPLE_CAP)

endmodule

`default_nettype wire

// ===== tb/tb_combined_lcg_shuffle_random.sv =====
// Testbench for combined_lcg_shuffle_random: predicts each random draw with its own model
// of the two generators and the shuffle table, and checks every result word against it.
// Depends on clsr_pkg and the RTL of combined_lcg_shuffle_random.
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_random;

   import clsr_pkg::TABLE_DEPTH;

   localparam longint unsigned MODULUS_A = 64'd2147483563;
   localparam longint unsigned MODULUS_B = 64'd2147483399;
   localparam longint unsigned MULT_A = 64'd40014;
   localparam longint unsigned MULT_B = 64'd40692;
   localparam longint unsigned WRAP_OFFSET = 64'd2147483562;
   localparam longint unsigned SLOT_SPAN = 64'd1 + 64'd2147483562 / TABLE_DEPTH;
   localparam logic [30:0] DRAW_CAP = 31'd2147483305;
   localparam logic [30:0] GEN_B_START = 31'd123456789;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [30:0] seed_out;
      logic [30:0] sample;
   } draw_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_seed_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [30:0] rsp_seed_out;
   logic [30:0] rsp_sample;

   logic [30:0] gen_b = GEN_B_START;
   logic [30:0] prev_draw = '0;
   logic [30:0] shuffle [TABLE_DEPTH] = '{default: '0};

   draw_t pending_draws [$];
   logic [31:0] chain_seed = 32'd1;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int mismatches = 0;
   int cycle_count = 0;

   combined_lcg_shuffle_random i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_seed_in  (req_seed_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_seed_out (rsp_seed_out),
      .rsp_sample   (rsp_sample)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // A seed of zero or below reseeds both generators and refills the table
   // before the ordinary step.
   function automatic draw_t draw_next(input logic [31:0] seed);
      longint unsigned gen_a;
      longint unsigned gen_b_base;
      longint unsigned diff;
      longint unsigned slot;
      draw_t d;
      gen_a = seed;
      gen_b_base = gen_b;
      if (seed == 32'd0 || seed[31]) begin
         gen_a = (seed == 32'd0) ? 64'd1 : 64'h1_0000_0000 - seed;
         gen_b_base = gen_a;
         for (int n = TABLE_DEPTH + 7; n >= 0; n--) begin
            gen_a = (gen_a * MULT_A) % MODULUS_A;
            if (n < TABLE_DEPTH) begin
               shuffle[n] = gen_a[30:0];
            end
         end
         prev_draw = shuffle[0];
      end
      gen_a = (gen_a * MULT_A) % MODULUS_A;
      gen_b = 31'((gen_b_base * MULT_B) % MODULUS_B);
      slot = prev_draw / SLOT_SPAN;
      if (slot >= TABLE_DEPTH) begin
         slot = TABLE_DEPTH - 1;
      end
      if (shuffle[slot] > gen_b) begin
         diff = longint'(shuffle[slot]) - longint'(gen_b);
      end else begin
         diff = WRAP_OFFSET + longint'(shuffle[slot]) - longint'(gen_b);
      end
      shuffle[slot] = gen_a[30:0];
      prev_draw = diff[30:0];
      d.seed_out = gen_a[30:0];
      d.sample = (diff[30:0] > DRAW_CAP) ? DRAW_CAP : diff[30:0];
      return d;
   endfunction

   always @(posedge clock) begin
      draw_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_draws.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("unexpected word: seed_out=%0d sample=%0d",
                           rsp_seed_out, rsp_sample);
               end
            end else begin
               want = pending_draws.pop_front();
               if (rsp_seed_out !== want.seed_out || rsp_sample !== want.sample) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("mismatch: seed_out exp %0d got %0d, sample exp %0d got %0d",
                              want.seed_out, rsp_seed_out, want.sample, rsp_sample);
                  end
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic offer_seed(input logic [31:0] seed);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_seed_in <= seed;
      do @(posedge clock); while (!req_ready);
      pending_draws.push_back(draw_next(seed));
      chain_seed = {1'b0, pending_draws[$].seed_out};
   endtask

   task automatic stop_sending;
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_drain;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_seeds;
      logic [31:0] corner_seeds [$];
      corner_seeds = '{32'd1, 32'd12345, 32'd2147483562, 32'd2147483563, 32'h7FFF_FFFF,
                       32'd0, 32'hFFFF_FFFF, -32'sd2147483562, 32'h8000_0000,
                       -32'sd2147483399, -32'sd2147483563, 32'h5555_5555, 32'h2AAA_AAAA,
                       32'h4000_0000, 32'd2, 32'd40014, -32'sd7};
      foreach (corner_seeds[k]) begin
         offer_seed(corner_seeds[k]);
      end
      repeat (6) offer_seed(chain_seed);
   endtask

   // Mostly chains fed back from the previous draw, broken by reseeds and
   // arbitrary seeds.
   task automatic test_random_draws(input int count);
      int pick;
      logic [31:0] seed;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            seed = 32'd0;
         end else if (pick < 3) begin
            seed = 32'h8000_0000;
         end else if (pick < 9) begin
            seed = $urandom | 32'h8000_0000;
         end else if (pick < 16) begin
            seed = $urandom;
         end else if (pick < 19) begin
            seed = $urandom_range(2147483563, 32'h7FFF_FFFF);
         end else begin
            seed = chain_seed;
         end
         offer_seed(seed);
      end
   endtask

   task automatic test_result_stall;
      hold_left <= 400;
      offer_seed(chain_seed);
      offer_seed(32'hFFFF_FF00);
      repeat (8) offer_seed(chain_seed);
      stop_sending();
      wait_for_drain();
   endtask

   task automatic test_drained_restart;
      repeat (5) offer_seed(chain_seed);
      stop_sending();
      wait_for_drain();
      offer_seed(32'd0);
      repeat (5) offer_seed(chain_seed);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 78;
      test_corner_seeds();
      test_random_draws(320);

      send_idle_pct = 78;
      recv_idle_pct = 21;
      test_random_draws(320);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_result_stall();
      test_drained_restart();
      test_random_draws(320);

      stop_sending();
      wait_for_drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_ctrl.sv
hw/rtl/clsr_dp.sv
hw/rtl/combined_lcg_shuffle_random.sv
tb/tb_combined_lcg_shuffle_random.sv
